### rtl/wrr_pkg.sv
// ----------------------------------------------------------------------------
// Weighted round-robin table package
// Shared types, codes and sizes for the weighted round-robin table.
// ----------------------------------------------------------------------------
package wrr_pkg;

  localparam int unsigned Entries = 16;
  localparam int unsigned SlotW   = 4;
  localparam int unsigned CountW  = 5;

  typedef enum logic [2:0] {
    FUNC_ADD    = 3'd0,
    FUNC_REMOVE = 3'd1,
    FUNC_PICK   = 3'd2,
    FUNC_QUERY  = 3'd3,
    FUNC_READ   = 3'd4,
    FUNC_CLEAR  = 3'd5,
    FUNC_RSV6   = 3'd6,
    FUNC_RSV7   = 3'd7
  } func_e;

  typedef enum logic [2:0] {
    ST_DONE      = 3'd0,
    ST_UPDATED   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_SEARCH = 2'd1,
    S_EXEC   = 2'd2,
    S_OUT    = 2'd3
  } state_e;

  typedef struct packed {
    logic [2:0]  func;
    logic [31:0] address;
    logic [15:0] weight;
    logic [3:0]  position;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] out_address;
    logic [3:0]  slot;
    logic [15:0] out_weight;
    logic [31:0] entry_served;
    logic [15:0] run_count;
    logic [4:0]  entries_in_use;
    logic [31:0] total_served;
  } out_t;

  // One search token moving down the cell chain.
  typedef struct packed {
    logic             vld;
    logic [31:0]      key;
    logic             hit;
    logic [SlotW-1:0] pos;
  } tok_t;

endpackage

### rtl/wrr_cell.sv
// ----------------------------------------------------------------------------
// Search cell
// Compares the passing token with one order position and hands it on.
// ----------------------------------------------------------------------------
module wrr_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [wrr_pkg::SlotW-1:0] my_pos_i,
  input  logic                      active_i,
  input  logic [31:0]               addr_i,
  input  wrr_pkg::tok_t             tok_i,
  output wrr_pkg::tok_t             tok_o
);

  wrr_pkg::tok_t tok_d, tok_q;

  always_comb begin
    tok_d = tok_i;
    if (tok_i.vld && !tok_i.hit && active_i && addr_i == tok_i.key) begin
      tok_d.hit = 1'b1;
      tok_d.pos = my_pos_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

### rtl/weighted_round_robin_table.sv
// Flow: add, remove and query pass through the cell chain search, then execute
// and output; pick, read, clear and unused codes go straight to execute and output.
// Throughput: one word at a time; the next is accepted once the result word
// is taken.
// Reset: count, cursor and total clear, order list goes to identity; entry
// contents are undefined until an add writes them.
// ----------------------------------------------------------------------------
// Weighted round-robin table
// Table of addresses served in weighted turns, searched by a chain of cells.
// ----------------------------------------------------------------------------
module weighted_round_robin_table (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  wrr_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output wrr_pkg::out_t out_data_o
);

  localparam int unsigned N = wrr_pkg::Entries;
  localparam int unsigned W = wrr_pkg::SlotW;

  // Entry store, indexed by slot.
  logic [31:0] ent_addr_q [N];
  logic [15:0] ent_wt_q   [N];
  logic [15:0] ent_run_q  [N];
  logic [31:0] ent_tot_q  [N];
  logic [W-1:0] order_q   [N];

  logic [wrr_pkg::CountW-1:0] count_q;
  logic [W-1:0]               cursor_q;
  logic [31:0]                total_q;

  wrr_pkg::state_e state_q, state_d;
  wrr_pkg::in_t    req_q;
  wrr_pkg::out_t   res_q;
  logic            hit_q;
  logic [W-1:0]    hpos_q;

  // Cell chain: token enters at cell 0, passes the register in each cell, and leaves at tok[N].
  wrr_pkg::tok_t tok [N+1];
  logic          act [N];
  logic [31:0]   cadr[N];

  logic accept;
  assign accept = in_valid_i && !in_stall_o;

  always_comb begin
    tok[0]     = '0;
    tok[0].vld = accept && (in_data_i.func == wrr_pkg::FUNC_ADD ||
                            in_data_i.func == wrr_pkg::FUNC_REMOVE ||
                            in_data_i.func == wrr_pkg::FUNC_QUERY);
    tok[0].key = in_data_i.address;
  end

  for (genvar g = 0; g < N; g++) begin : g_cell
    assign act[g]  = {1'b0, W'(g)} < count_q;
    assign cadr[g] = ent_addr_q[order_q[g]];
    wrr_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .my_pos_i (W'(g)),
      .active_i (act[g]),
      .addr_i   (cadr[g]),
      .tok_i    (tok[g]),
      .tok_o    (tok[g+1])
    );
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      wrr_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = tok[0].vld ? wrr_pkg::S_SEARCH : wrr_pkg::S_EXEC;
        end
      end
      wrr_pkg::S_SEARCH: if (tok[N].vld) state_d = wrr_pkg::S_EXEC;
      wrr_pkg::S_EXEC:   state_d = wrr_pkg::S_OUT;
      wrr_pkg::S_OUT:    if (!out_stall_i) state_d = wrr_pkg::S_IDLE;
      default:           state_d = wrr_pkg::S_IDLE;
    endcase
  end

  // Outputs of the FSM.
  always_comb begin
    in_stall_o  = (state_q != wrr_pkg::S_IDLE);
    out_valid_o = (state_q == wrr_pkg::S_OUT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wrr_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) req_q <= in_data_i;
    if (state_q == wrr_pkg::S_SEARCH && tok[N].vld) begin
      hit_q  <= tok[N].hit;
      hpos_q <= tok[N].pos;
    end
  end

  // Execute: one table access per item.
  logic [W-1:0]  pick_cur, ex_slot, last_pos, cur_nxt;
  logic [15:0]   run_inc, lim;
  logic [31:0]   tot_inc;
  logic          run_end;
  logic          ex_exec;
  wrr_pkg::out_t res_d;

  assign ex_exec  = (state_q == wrr_pkg::S_EXEC);
  assign pick_cur = ({1'b0, cursor_q} >= count_q) ? '0 : cursor_q;
  assign last_pos = W'(count_q - 1'b1);

  always_comb begin
    ex_slot = order_q[hpos_q];
    unique case (wrr_pkg::func_e'(req_q.func))
      wrr_pkg::FUNC_ADD:  if (!hit_q) ex_slot = order_q[count_q[W-1:0]];
      wrr_pkg::FUNC_PICK: ex_slot = order_q[pick_cur];
      wrr_pkg::FUNC_READ: ex_slot = order_q[req_q.position];
      default: ;
    endcase
  end

  assign run_inc = (ent_run_q[ex_slot] != 16'hFFFF) ? ent_run_q[ex_slot] + 16'd1
                                                   : ent_run_q[ex_slot];
  assign tot_inc = (ent_tot_q[ex_slot] != 32'hFFFF_FFFF) ? ent_tot_q[ex_slot] + 32'd1
                                                        : ent_tot_q[ex_slot];
  assign lim     = (ent_wt_q[ex_slot] == 16'd0) ? 16'd1 : ent_wt_q[ex_slot];
  assign run_end = run_inc >= lim;
  assign cur_nxt = ({1'b0, pick_cur} + 1'b1 >= count_q) ? '0 : W'(pick_cur + 1'b1);

  always_comb begin
    res_d                = '0;
    res_d.status         = wrr_pkg::ST_DONE;
    res_d.out_address    = ent_addr_q[ex_slot];
    res_d.slot           = ex_slot;
    res_d.out_weight     = ent_wt_q[ex_slot];
    res_d.entry_served   = ent_tot_q[ex_slot];
    res_d.run_count      = ent_run_q[ex_slot];
    res_d.entries_in_use = count_q;
    res_d.total_served   = total_q;
    unique case (wrr_pkg::func_e'(req_q.func))
      wrr_pkg::FUNC_ADD: begin
        if (hit_q) begin
          res_d.status     = wrr_pkg::ST_UPDATED;
          res_d.out_weight = req_q.weight;
        end else if (count_q >= wrr_pkg::CountW'(N)) begin
          res_d = '0; res_d.status = wrr_pkg::ST_FULL;
          res_d.entries_in_use = count_q; res_d.total_served = total_q;
        end else begin
          res_d.out_address    = req_q.address;
          res_d.out_weight     = req_q.weight;
          res_d.entry_served   = '0;
          res_d.run_count      = '0;
          res_d.entries_in_use = count_q + 1'b1;
        end
      end
      wrr_pkg::FUNC_REMOVE, wrr_pkg::FUNC_QUERY: begin
        if (!hit_q) begin
          res_d = '0; res_d.status = wrr_pkg::ST_NOT_FOUND;
          res_d.entries_in_use = count_q; res_d.total_served = total_q;
        end else if (req_q.func == wrr_pkg::FUNC_REMOVE) begin
          res_d.entries_in_use = count_q - 1'b1;
        end
      end
      wrr_pkg::FUNC_PICK: begin
        if (count_q == '0) begin
          res_d = '0; res_d.status = wrr_pkg::ST_EMPTY;
          res_d.total_served = total_q;
        end else begin
          res_d.entry_served = tot_inc;
          res_d.run_count    = run_end ? 16'd0 : run_inc;
          res_d.total_served = (total_q != 32'hFFFF_FFFF) ? total_q + 32'd1 : total_q;
        end
      end
      wrr_pkg::FUNC_READ: begin
        if ({1'b0, req_q.position} >= count_q) begin
          res_d = '0; res_d.status = wrr_pkg::ST_NOT_FOUND;
          res_d.entries_in_use = count_q; res_d.total_served = total_q;
        end
      end
      default: begin
        res_d = '0;
        res_d.entries_in_use = (req_q.func == wrr_pkg::FUNC_CLEAR) ? '0 : count_q;
        res_d.total_served   = (req_q.func == wrr_pkg::FUNC_CLEAR) ? '0 : total_q;
      end
    endcase
  end

  // Entry store writes; the store has no reset.
  always_ff @(posedge clk_i) begin
    if (ex_exec) begin
      res_q <= res_d;
      if (req_q.func == wrr_pkg::FUNC_ADD) begin
        if (hit_q) begin
          ent_wt_q[ex_slot] <= req_q.weight;
        end else if (count_q < wrr_pkg::CountW'(N)) begin
          ent_addr_q[ex_slot] <= req_q.address;
          ent_wt_q[ex_slot]   <= req_q.weight;
          ent_run_q[ex_slot]  <= '0;
          ent_tot_q[ex_slot]  <= '0;
        end
      end else if (req_q.func == wrr_pkg::FUNC_PICK && count_q != '0) begin
        ent_run_q[ex_slot] <= run_end ? 16'd0 : run_inc;
        ent_tot_q[ex_slot] <= tot_inc;
      end
    end
  end

  // Control state: order list, count, cursor, total.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < N; i++) order_q[i] <= W'(i);
      count_q  <= '0;
      cursor_q <= '0;
      total_q  <= '0;
    end else if (ex_exec) begin
      unique case (wrr_pkg::func_e'(req_q.func))
        wrr_pkg::FUNC_ADD: begin
          if (!hit_q && count_q < wrr_pkg::CountW'(N)) count_q <= count_q + 1'b1;
        end
        wrr_pkg::FUNC_REMOVE: begin
          if (hit_q) begin
            order_q[last_pos] <= order_q[hpos_q];
            order_q[hpos_q]   <= order_q[last_pos];
            count_q           <= count_q - 1'b1;
          end
        end
        wrr_pkg::FUNC_PICK: begin
          if (count_q != '0) begin
            cursor_q <= run_end ? cur_nxt : pick_cur;
            if (total_q != 32'hFFFF_FFFF) total_q <= total_q + 32'd1;
          end
        end
        wrr_pkg::FUNC_CLEAR: begin
          for (int i = 0; i < N; i++) order_q[i] <= W'(i);
          count_q  <= '0;
          cursor_q <= '0;
          total_q  <= '0;
        end
        default: ;
      endcase
    end
  end

  assign out_data_o = res_q;

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= wrr_pkg::CountW'(N)) else $error("count exceeds table size");
  a_out_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ex_exec |=> out_valid_o) else $error("result not presented after execute");
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok[0].vld |=> state_q == wrr_pkg::S_SEARCH) else $error("search not started");
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ex_exec |=> $stable(count_q)) else $error("count changed outside execute");
`endif

endmodule

### bench/tb_weighted_round_robin_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Weighted round-robin table testbench
// Drives command words into the table, predicts each result word with a local
// model of the table, and compares every field of every result in order.
// ----------------------------------------------------------------------------
module tb_weighted_round_robin_table;

  localparam int unsigned CycleLimit = 400000;

  logic           clk_i;
  logic           rst_ni;
  logic           in_valid_i;
  logic           in_stall_o;
  wrr_pkg::in_t   in_data_i;
  logic           out_valid_o;
  logic           out_stall_i;
  wrr_pkg::out_t  out_data_o;

  weighted_round_robin_table dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // Clock: 10 ns period.
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Shadow copy of the table state.
  logic [31:0]               tbl_addr  [wrr_pkg::Entries];
  logic [15:0]               tbl_wt    [wrr_pkg::Entries];
  logic [15:0]               tbl_run   [wrr_pkg::Entries];
  logic [31:0]               tbl_total [wrr_pkg::Entries];
  logic [wrr_pkg::SlotW-1:0] tbl_order [wrr_pkg::Entries];
  int unsigned               tbl_count;
  int unsigned               tbl_cursor;
  logic [31:0]               tbl_served;

  wrr_pkg::out_t expected_words[$];
  int unsigned   mismatch_count;
  int unsigned   cycle_count;
  bit            idle_enable;     // random idling on both sides
  bit            hold_off;        // long receiver stall in progress

  // Keep a pool of addresses so adds, removes and queries collide often.
  logic [31:0] addr_pool[24];

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  function automatic void reset_table();
    for (int i = 0; i < wrr_pkg::Entries; i++) begin
      tbl_addr[i]  = '0;
      tbl_wt[i]    = '0;
      tbl_run[i]   = '0;
      tbl_total[i] = '0;
      tbl_order[i] = wrr_pkg::SlotW'(i);
    end
    tbl_count  = 0;
    tbl_cursor = 0;
    tbl_served = '0;
  endfunction

  function automatic int unsigned find_position(input logic [31:0] a);
    for (int i = 0; i < tbl_count; i++)
      if (tbl_addr[tbl_order[i]] == a) return i;
    return wrr_pkg::Entries;
  endfunction

  function automatic void fill_entry(inout wrr_pkg::out_t r,
                                     input logic [wrr_pkg::SlotW-1:0] s);
    r.out_address  = tbl_addr[s];
    r.slot         = s;
    r.out_weight   = tbl_wt[s];
    r.entry_served = tbl_total[s];
    r.run_count    = tbl_run[s];
  endfunction

  // Apply one command word to the shadow table and return the result word.
  function automatic wrr_pkg::out_t apply_command(input wrr_pkg::in_t w);
    wrr_pkg::out_t             r;
    int unsigned               p;
    logic [wrr_pkg::SlotW-1:0] s;
    logic [wrr_pkg::SlotW-1:0] tmp;
    logic [15:0]               lim;
    r = '0;
    r.status = wrr_pkg::ST_DONE;
    case (wrr_pkg::func_e'(w.func))
      wrr_pkg::FUNC_ADD: begin
        p = find_position(w.address);
        if (p < wrr_pkg::Entries) begin
          s = tbl_order[p];
          tbl_wt[s] = w.weight;
          r.status = wrr_pkg::ST_UPDATED;
          fill_entry(r, s);
        end else if (tbl_count >= wrr_pkg::Entries) begin
          r.status = wrr_pkg::ST_FULL;
        end else begin
          s = tbl_order[tbl_count];
          tbl_addr[s]  = w.address;
          tbl_wt[s]    = w.weight;
          tbl_run[s]   = '0;
          tbl_total[s] = '0;
          tbl_count++;
          fill_entry(r, s);
        end
      end
      wrr_pkg::FUNC_REMOVE: begin
        p = find_position(w.address);
        if (p >= wrr_pkg::Entries) begin
          r.status = wrr_pkg::ST_NOT_FOUND;
        end else begin
          s = tbl_order[p];
          fill_entry(r, s);
          tmp = tbl_order[tbl_count-1];
          tbl_order[tbl_count-1] = tbl_order[p];
          tbl_order[p] = tmp;
          tbl_count--;
        end
      end
      wrr_pkg::FUNC_PICK: begin
        if (tbl_count == 0) begin
          r.status = wrr_pkg::ST_EMPTY;
        end else begin
          // A cursor left past the end by a remove restarts at the head.
          if (tbl_cursor >= tbl_count) tbl_cursor = 0;
          s = tbl_order[tbl_cursor];
          if (tbl_run[s] != 16'hFFFF) tbl_run[s]++;
          if (tbl_total[s] != 32'hFFFF_FFFF) tbl_total[s]++;
          lim = (tbl_wt[s] == 0) ? 16'd1 : tbl_wt[s];
          if (tbl_run[s] >= lim) begin
            tbl_run[s] = '0;
            tbl_cursor++;
            if (tbl_cursor >= tbl_count) tbl_cursor = 0;
          end
          if (tbl_served != 32'hFFFF_FFFF) tbl_served++;
          fill_entry(r, s);
        end
      end
      wrr_pkg::FUNC_QUERY: begin
        p = find_position(w.address);
        if (p >= wrr_pkg::Entries) r.status = wrr_pkg::ST_NOT_FOUND;
        else fill_entry(r, tbl_order[p]);
      end
      wrr_pkg::FUNC_READ: begin
        if (w.position >= tbl_count) r.status = wrr_pkg::ST_NOT_FOUND;
        else fill_entry(r, tbl_order[w.position]);
      end
      wrr_pkg::FUNC_CLEAR: reset_table();
      default: ;
    endcase
    r.entries_in_use = wrr_pkg::CountW'(tbl_count);
    r.total_served   = tbl_served;
    return r;
  endfunction

  // Send one word: random gap first, then hold valid until it is taken.
  task automatic send_word(input wrr_pkg::in_t w);
    int unsigned gap;
    gap = 0;
    if (idle_enable && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 6);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_words.push_back(apply_command(w));
  endtask

  function automatic wrr_pkg::in_t make_word(input wrr_pkg::func_e f,
                                             input logic [31:0] a,
                                             input logic [15:0] wt,
                                             input logic [3:0] pos);
    wrr_pkg::in_t w;
    w.func     = f;
    w.address  = a;
    w.weight   = wt;
    w.position = pos;
    return w;
  endfunction

  function automatic logic [31:0] pool_address();
    return addr_pool[$urandom_range(0, 23)];
  endfunction

  // Random word, weighted toward traffic that keeps the table populated.
  function automatic wrr_pkg::in_t random_word();
    int unsigned k;
    logic [15:0] wt;
    k  = $urandom_range(0, 99);
    wt = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
    if (k < 25) return make_word(wrr_pkg::FUNC_ADD, pool_address(), wt, 4'($urandom));
    if (k < 35) return make_word(wrr_pkg::FUNC_REMOVE, pool_address(), 16'($urandom),
                                 4'($urandom));
    if (k < 70) return make_word(wrr_pkg::FUNC_PICK, $urandom, 16'($urandom),
                                 4'($urandom));
    if (k < 80) return make_word(wrr_pkg::FUNC_QUERY, pool_address(), 16'($urandom),
                                 4'($urandom));
    if (k < 92) return make_word(wrr_pkg::FUNC_READ, $urandom, 16'($urandom),
                                 4'($urandom));
    if (k < 94) return make_word(wrr_pkg::FUNC_CLEAR, $urandom, 16'($urandom),
                                 4'($urandom));
    if (k < 96) return make_word(wrr_pkg::func_e'($urandom_range(6, 7)), $urandom,
                                 16'($urandom), 4'($urandom));
    return make_word(wrr_pkg::FUNC_ADD, $urandom, 16'($urandom), 4'($urandom));
  endfunction

  // Drop valid, wait for every expected word, then let the block settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (25) @(posedge clk_i);
  endtask

  // Extremes, every function, full and empty table, unused codes.
  task automatic test_directed();
    send_word(make_word(wrr_pkg::FUNC_PICK, '0, '0, '0));
    send_word(make_word(wrr_pkg::FUNC_REMOVE, 32'hFFFF_FFFF, '0, '0));
    send_word(make_word(wrr_pkg::FUNC_READ, '0, '0, 4'hF));
    send_word(make_word(wrr_pkg::FUNC_ADD, 32'h0000_0000, 16'h0000, '0));
    send_word(make_word(wrr_pkg::FUNC_ADD, 32'hFFFF_FFFF, 16'hFFFF, 4'hF));
    send_word(make_word(wrr_pkg::FUNC_PICK, '0, '0, '0));
    send_word(make_word(wrr_pkg::FUNC_PICK, '0, '0, '0));
    send_word(make_word(wrr_pkg::FUNC_PICK, '0, '0, '0));
    // Lower the weight mid run so the run overshoots it.
    send_word(make_word(wrr_pkg::FUNC_ADD, 32'hFFFF_FFFF, 16'h0001, '0));
    send_word(make_word(wrr_pkg::FUNC_PICK, '0, '0, '0));
    send_word(make_word(wrr_pkg::FUNC_QUERY, 32'hFFFF_FFFF, '0, '0));
    send_word(make_word(wrr_pkg::FUNC_READ, '0, '0, 4'h1));
    send_word(make_word(wrr_pkg::FUNC_REMOVE, 32'h0000_0000, '0, '0));
    send_word(make_word(wrr_pkg::FUNC_PICK, '0, '0, '0));
    send_word(make_word(wrr_pkg::FUNC_RSV6, 32'hA5A5_A5A5, 16'h5A5A, 4'hA));
    send_word(make_word(wrr_pkg::FUNC_RSV7, 32'h5A5A_5A5A, 16'hA5A5, 4'h5));
    for (int i = 0; i < 17; i++)
      send_word(make_word(wrr_pkg::FUNC_ADD, 32'h1000_0000 + i, 16'(i), 4'(i)));
    send_word(make_word(wrr_pkg::FUNC_READ, '0, '0, 4'hF));
    send_word(make_word(wrr_pkg::FUNC_CLEAR, '0, '0, '0));
    send_word(make_word(wrr_pkg::FUNC_QUERY, 32'h1000_0000, '0, '0));
  endtask

  // Long receiver hold-off while words keep coming: the block must stall.
  task automatic test_backpressure();
    hold_off = 1'b1;
    for (int i = 0; i < 12; i++) send_word(random_word());
    drain();
  endtask

  task automatic test_random(input int unsigned n);
    for (int i = 0; i < n; i++) send_word(random_word());
  endtask

  // Long stall counted in its own process.
  initial begin
    wait (hold_off);
    repeat (300) @(posedge clk_i);
    hold_off = 1'b0;
  end

  // Receiver: random stall bursts, plus the long hold-off.
  initial begin
    int unsigned burst;
    out_stall_i = 1'b0;
    burst = 0;
    forever begin
      @(posedge clk_i);
      if (burst != 0) burst--;
      else if (idle_enable && $urandom_range(0, 4) == 0) burst = $urandom_range(1, 6);
      out_stall_i <= hold_off || (burst != 0);
    end
  end

  // Check every accepted result word against the oldest prediction.
  always @(posedge clk_i) begin
    wrr_pkg::out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_words.size() == 0) begin
        report_mismatch("unexpected word", out_data_o.status, 0);
      end else begin
        want = expected_words.pop_front();
        if (out_data_o.status != want.status)
          report_mismatch("status", out_data_o.status, want.status);
        if (out_data_o.out_address != want.out_address)
          report_mismatch("out_address", out_data_o.out_address, want.out_address);
        if (out_data_o.slot != want.slot)
          report_mismatch("slot", out_data_o.slot, want.slot);
        if (out_data_o.out_weight != want.out_weight)
          report_mismatch("out_weight", out_data_o.out_weight, want.out_weight);
        if (out_data_o.entry_served != want.entry_served)
          report_mismatch("entry_served", out_data_o.entry_served, want.entry_served);
        if (out_data_o.run_count != want.run_count)
          report_mismatch("run_count", out_data_o.run_count, want.run_count);
        if (out_data_o.entries_in_use != want.entries_in_use)
          report_mismatch("entries_in_use", out_data_o.entries_in_use,
                          want.entries_in_use);
        if (out_data_o.total_served != want.total_served)
          report_mismatch("total_served", out_data_o.total_served, want.total_served);
      end
    end
  end

  // Watchdog: end the run on a hang.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_data_i      = '0;
    idle_enable    = 1'b1;
    hold_off       = 1'b0;
    mismatch_count = 0;
    cycle_count    = 0;
    reset_table();
    for (int i = 0; i < 24; i++) addr_pool[i] = $urandom;
    addr_pool[0] = 32'h0000_0000;
    addr_pool[1] = 32'hFFFF_FFFF;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_backpressure();
    test_random(1600);
    // Last stretch: no idling on either side.
    idle_enable = 1'b0;
    test_random(300);
    drain();

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/wrr_pkg.sv
rtl/wrr_cell.sv
rtl/weighted_round_robin_table.sv
bench/tb_weighted_round_robin_table.sv
